// ===== hw/rtl/ima_pkg.sv =====
// ----------------------------------------------------------------------------
// ima_pkg - shared types and tables for the IMA ADPCM decoder
// Holds the decoder state type, the standard step table and the index table.
// ----------------------------------------------------------------------------
package ima_pkg;

	// Largest legal step table index
	localparam logic [6:0] IDX_MAX = 7'd88;

	// Configuration register indexes
	localparam logic CFG_START_PREDICTOR  = 1'b0;
	localparam logic CFG_START_STEP_INDEX = 1'b1;

	// Decoder state carried between nibbles
	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0]         idx;
	} ima_state_t;

	// Standard IMA step table; index 88 and all indexes above it read 32767
	function automatic logic [14:0] step_table(input logic [6:0] idx);
		logic [14:0] s;
		case (idx)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
			7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
			7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
			7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
			7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
			7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
			7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
			7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
			7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
			7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
			7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
			7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
			7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
			7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
			7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
			7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	// Standard IMA index adjustment, keyed by the magnitude bits
	function automatic logic signed [4:0] idx_delta(input logic [2:0] mag);
		logic signed [4:0] d;
		case (mag)
			3'd4:    d = 5'sd2;
			3'd5:    d = 5'sd4;
			3'd6:    d = 5'sd6;
			3'd7:    d = 5'sd8;
			default: d = -5'sd1;
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/ima_step_unit.sv =====
// ----------------------------------------------------------------------------
// ima_step_unit - one IMA ADPCM nibble decode
// Builds the difference from the step, applies it with saturation and moves
// the step index, all in one short combinational path.
// ----------------------------------------------------------------------------
module ima_step_unit (
	input  ima_pkg::ima_state_t cur,
	input  logic [3:0]          code,
	output ima_pkg::ima_state_t nxt
);

	logic [14:0]        step;
	logic [16:0]        diff;
	logic signed [17:0] sum;
	logic signed [8:0]  ni;
	logic signed [15:0] pred_nxt;
	logic [6:0]         idx_nxt;

	// Difference from the magnitude bits
	always_comb begin
		step = ima_pkg::step_table(cur.idx);
		diff = 17'(step >> 3);
		if (code[2]) diff = diff + 17'(step);
		if (code[1]) diff = diff + 17'(step >> 1);
		if (code[0]) diff = diff + 17'(step >> 2);
	end

	// Full-precision add or subtract, then saturate to 16 bits
	always_comb begin
		if (code[3]) begin
			sum = 18'(cur.pred) - $signed({1'b0, diff});
		end else begin
			sum = 18'(cur.pred) + $signed({1'b0, diff});
		end
		if (sum > 18'sd32767) begin
			pred_nxt = 16'sh7fff;
		end else if (sum < -18'sd32768) begin
			pred_nxt = 16'sh8000;
		end else begin
			pred_nxt = sum[15:0];
		end
	end

	// Step index update, clamped to the table
	always_comb begin
		ni = $signed({2'b00, cur.idx}) + 9'(ima_pkg::idx_delta(code[2:0]));
		if (ni < 9'sd0) begin
			idx_nxt = 7'd0;
		end else if (ni > $signed({2'b00, ima_pkg::IDX_MAX})) begin
			idx_nxt = ima_pkg::IDX_MAX;
		end else begin
			idx_nxt = ni[6:0];
		end
	end

	assign nxt = {pred_nxt, idx_nxt};

endmodule

// ===== hw/rtl/ima_adpcm_decoder.sv =====
// ----------------------------------------------------------------------------
// ima_adpcm_decoder - IMA ADPCM 4-bit stream decoder
// Bytes of two codes in, one 16-bit sample per code out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one byte per transaction, high nibble decoded first.
//   s_tuser[0] = high_only (decode the high nibble only), s_tuser[1] =
//   restart (load predictor and step index from the config registers first).
//   Output stream m_*: one sample per transaction, m_tlast marks the final
//   sample of a byte.
//   Config port: cfg_we/cfg_index/cfg_data; index 0 is the start predictor,
//   index 1 the start step index (values above 88 load as 88). Write only
//   while the stream is idle.
// Timing:
//   A byte is held in an input register and decoded one nibble per cycle,
//   while the output is not stalled, by a single step unit into the output
//   register; a full byte yields two samples, a high-only byte one. The next
//   byte is taken in the cycle its predecessor's last nibble is decoded.
// Reset: clears predictor, step index, config registers and all valids.
// Stall: when m_tvalid is high and m_tready low the output register holds,
//   decoding stops and s_tready drops once the input register is occupied.
// ----------------------------------------------------------------------------
module ima_adpcm_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] code_byte
	input  logic [1:0]  s_tuser,   // [0] high_only, [1] restart
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] sample_wide, [23:16] sample_narrow
	output logic        m_tlast
);

	logic signed [15:0]  start_pred_q;
	logic [6:0]          start_idx_q;
	ima_pkg::ima_state_t state_q;
	ima_pkg::ima_state_t cur;
	ima_pkg::ima_state_t nxt;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       ho_s1;
	logic       rst_s1;
	logic       phase_q;
	logic       adv;
	logic       last;
	logic [3:0] code;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pred_q <= '0;
			start_idx_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ima_pkg::CFG_START_PREDICTOR:  start_pred_q <= cfg_data;
				ima_pkg::CFG_START_STEP_INDEX: start_idx_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Handshake and nibble select
	assign adv      = v_s1 && (!m_tvalid || m_tready);
	assign last     = ho_s1 || phase_q;
	assign s_tready = !v_s1 || (adv && last);
	assign code     = phase_q ? byte_s1[3:0] : byte_s1[7:4];

	// Restart loads the start values ahead of the high nibble
	always_comb begin
		cur = state_q;
		if (rst_s1 && !phase_q) begin
			cur.pred = start_pred_q;
			cur.idx  = (start_idx_q > ima_pkg::IDX_MAX) ? ima_pkg::IDX_MAX
			                                            : start_idx_q;
		end
	end

	ima_step_unit u_step (
		.cur  (cur),
		.code (code),
		.nxt  (nxt)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				v_s1    <= 1'b1;
				phase_q <= 1'b0;
			end else if (adv) begin
				if (last) begin
					v_s1    <= 1'b0;
					phase_q <= 1'b0;
				end else begin
					phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			ho_s1   <= s_tuser[0];
			rst_s1  <= s_tuser[1];
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {nxt.pred[15:8], nxt.pred};
			m_tlast <= last;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.idx <= ima_pkg::IDX_MAX)
		else $error("step index left the table");

	a_phase_valid: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (v_s1 && !ho_s1))
		else $error("second nibble without a full byte held");

	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:16] == m_tdata[15:8]))
		else $error("narrow sample does not match wide sample");

	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while decoder stalled");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("decoder state changed without a decode");
`endif

endmodule
